// File: rtl/core/b64d_pkg.sv
package b64d_pkg;

  // default depth of the symbol queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // closing status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LENGTH    = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_AFTER_PAD = 2'd3;

  // symbol classes produced by the front
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_PAD  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic [1:0] status;
    logic       end_of_string;
  } out_beat_t;

  // one classified character
  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] value;
    logic       last;
  } sym_t;

  // queue to back handshake
  typedef struct packed {
    logic valid;
    sym_t sym;
  } q_head_t;

endpackage

// File: rtl/core/base64_decoder_checked_unit.sv
// base64 decoder, one encoded character per input beat
//
// input channel: in_valid / in_stall, in_data carries the character and a
// flag on the last character of the string. output channel: out_valid /
// out_stall, out_data is either a decoded byte (is_data high) or the
// closing status beat of a string (end_of_string high, status code).
// a character gives zero, one or two output beats: a byte when eight bits
// are ready, then the status beat when it is the last character.
// cfg_write / cfg_data load the alphabet select bit (0 standard, 1 url
// safe); write it only while no string is in flight.
// throughput: one character per cycle while the receiver does not stall;
// the back end drains one output beat per cycle, so a last character that
// also yields a byte holds off the next pop while its status beat is
// parked. the front classifies each character through the alphabet table
// and pushes it into a small symbol queue; the back end updates the bit
// accumulator and holds results in an output register.
// receiver stall: the output register holds, the back end stops popping,
// and the queue absorbs up to DEPTH characters before in_stall rises.
// reset: synchronous, clears queue, per-string state, output valid and
// selects the standard alphabet.
module base64_decoder_checked_unit #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  input  b64d_pkg::in_beat_t  in_data,
  output logic                in_stall,
  output logic                out_valid,
  output b64d_pkg::out_beat_t out_data,
  input  logic                out_stall
);
  import b64d_pkg::*;

  // front to queue
  logic    push;
  sym_t    push_sym;
  logic    q_full;

  // queue to back
  q_head_t head;
  logic    pop;

  // classify characters, own the alphabet register
  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_sym  (push_sym)
  );

  // decouples input acceptance from output back-pressure
  b64d_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_sym (push_sym),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  // bit accumulator, error tracking and output register
  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// File: rtl/core/b64d_front.sv
module b64d_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  input  b64d_pkg::in_beat_t in_data,
  output logic               in_stall,
  input  logic               q_full,
  output logic               push,
  output b64d_pkg::sym_t     push_sym
);
  import b64d_pkg::*;

  logic alphabet_select;

  function automatic sym_t classify(input logic [7:0] c, input logic url, input logic last);
    sym_t s;
    s.kind  = KIND_DATA;
    s.value = '0;
    s.last  = last;
    if (c inside {[8'h41:8'h5A]}) begin
      s.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.value = 6'(c - 8'd71);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.value = 6'(c + 8'd4);
    end else if (c == 8'h3D) begin
      s.kind = KIND_PAD;
    end else if (url && c == 8'h2D) begin
      s.value = 6'd62;
    end else if (url && c == 8'h5F) begin
      s.value = 6'd63;
    end else if (!url && c == 8'h2B) begin
      s.value = 6'd62;
    end else if (!url && c == 8'h2F) begin
      s.value = 6'd63;
    end else begin
      s.kind = KIND_BAD;
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_select <= 1'b0;
    end else if (cfg_write) begin
      alphabet_select <= cfg_data;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign push_sym = classify(in_data.in_char, alphabet_select, in_data.in_last);

endmodule

// File: rtl/core/b64d_queue.sv
module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64d_pkg::sym_t    push_sym,
  output logic              full,
  input  logic              pop,
  output b64d_pkg::q_head_t head
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sym_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head.valid = (count != '0);
  assign head.sym   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/b64d_back.sv
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  b64d_pkg::q_head_t   head,
  output logic                pop,
  output logic                out_valid,
  output b64d_pkg::out_beat_t out_data,
  input  logic                out_stall
);
  import b64d_pkg::*;

  // per-string state
  logic [11:0] bit_accumulator;
  logic [2:0]  bit_count;
  logic        padding_seen;
  logic [1:0]  char_count_mod4;
  logic [1:0]  first_error;

  logic [11:0] bit_accumulator_next;
  logic [2:0]  bit_count_next;
  logic        padding_seen_next;
  logic [1:0]  char_count_mod4_next;
  logic [1:0]  first_error_next;

  // status beat parked behind a data beat
  logic        pend_valid;
  out_beat_t   pend_data;

  logic        can_load;
  logic        data_fire;
  logic [3:0]  sum;
  logic [11:0] shifted;
  out_beat_t   data_beat;
  out_beat_t   status_beat;

  assign can_load = !out_valid || !out_stall;
  assign pop      = can_load && !pend_valid && head.valid;

  always_comb begin
    bit_accumulator_next = bit_accumulator;
    bit_count_next       = bit_count;
    padding_seen_next    = padding_seen;
    char_count_mod4_next = char_count_mod4 + 2'd1;
    first_error_next     = first_error;
    data_fire            = 1'b0;
    sum                  = {1'b0, bit_count} + 4'd6;
    case (head.sym.kind)
      KIND_BAD: begin
        if (first_error == ST_OK) first_error_next = ST_INVALID;
      end
      KIND_PAD: begin
        padding_seen_next = 1'b1;
      end
      KIND_DATA: begin
        if (padding_seen) begin
          if (first_error == ST_OK) first_error_next = ST_AFTER_PAD;
        end else begin
          bit_accumulator_next = {bit_accumulator[5:0], head.sym.value};
          if (sum >= 4'd8) begin
            bit_count_next = 3'(sum - 4'd8);
            data_fire      = (first_error == ST_OK);
          end else begin
            bit_count_next = 3'(sum);
          end
        end
      end
      default: ;
    endcase
    shifted = bit_accumulator_next >> bit_count_next;

    data_beat.out_byte      = shifted[7:0];
    data_beat.is_data       = 1'b1;
    data_beat.status        = ST_OK;
    data_beat.end_of_string = 1'b0;

    status_beat.out_byte      = '0;
    status_beat.is_data       = 1'b0;
    status_beat.status        = (char_count_mod4_next != 2'd0) ? ST_LENGTH : first_error_next;
    status_beat.end_of_string = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator <= '0;
      bit_count       <= '0;
      padding_seen    <= 1'b0;
      char_count_mod4 <= '0;
      first_error     <= ST_OK;
      out_valid       <= 1'b0;
      pend_valid      <= 1'b0;
    end else begin
      if (pop) begin
        if (head.sym.last) begin
          bit_accumulator <= '0;
          bit_count       <= '0;
          padding_seen    <= 1'b0;
          char_count_mod4 <= '0;
          first_error     <= ST_OK;
        end else begin
          bit_accumulator <= bit_accumulator_next;
          bit_count       <= bit_count_next;
          padding_seen    <= padding_seen_next;
          char_count_mod4 <= char_count_mod4_next;
          first_error     <= first_error_next;
        end
      end
      if (can_load) begin
        if (pend_valid) begin
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (pop) begin
          out_valid  <= data_fire || head.sym.last;
          pend_valid <= data_fire && head.sym.last;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend_valid) begin
        out_data <= pend_data;
      end else if (pop) begin
        out_data  <= data_fire ? data_beat : status_beat;
        pend_data <= status_beat;
      end
    end
  end

endmodule

// File: rtl/core/b64d_checker.sv
module b64d_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input b64d_pkg::out_beat_t out_data,
  input logic                out_stall
);
  import b64d_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat right after reset");

  // a data beat carries ok status and no end mark
  a_data_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_data |-> out_data.status == ST_OK && !out_data.end_of_string)
    else $error("data beat with status or end mark");

  // a status beat carries a zero byte and the end mark
  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_data |-> out_data.out_byte == 8'd0 && out_data.end_of_string)
    else $error("status beat malformed");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

bind base64_decoder_checked_unit b64d_checker u_b64d_checker (.*);
